>>> rtl/core/kfi_pkg.sv
// shared types and constants of the keyframe interpolator
package kfi_pkg;

   localparam int VAL_W = 32;
   localparam int CH_N = 3;
   localparam int CH_W = 2;
   localparam int REQ_W = 168;
   localparam int RSP_W = CH_N * VAL_W;
   localparam int CSR_W = 5;
   localparam int DIV_STEPS = 64;
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(CH_N - 1);

   // command codes carried in tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // interpolation modes
   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_LINEAR = 1'b1;

   // register indexes
   localparam logic CSR_IDX_MODE = 1'b0;
   localparam logic CSR_IDX_COUNT = 1'b1;

   // one knot: time in the low bits, then channels a, b, c
   typedef struct packed {
      logic [CH_N-1:0][VAL_W-1:0] val;
      logic [VAL_W-1:0] tm;
   } knot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_CHK_SCAN,
      ST_NEAR,
      ST_SPAN,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_DELIVER
   } state_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_ZERO,
      RES_RD,
      RES_PREV,
      RES_CUR,
      RES_LIN
   } res_sel_type;

   typedef struct packed {
      logic take;
      res_sel_type res_sel;
      logic load_prev;
      logic load_cur;
      logic prep;
      logic mul;
      logic div_step;
      logic rsp_load;
      logic [CH_W-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic t_le_rd;
      logic t_ge_rd;
      logic seg_found;
      logic cur_closer;
      logic span_zero;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/core/kfi_ctrl.sv
// controller: query sequencing, knot scan and register file
module kfi_ctrl #(
   parameter int MAX_KNOTS = 16,
   parameter int IDX_W = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [kfi_pkg::CSR_W-1:0] csr_data,
   input  kfi_pkg::status_type status,
   output kfi_pkg::cmd_type cmd,
   output logic [IDX_W-1:0] rd_addr
);
   import kfi_pkg::*;

   localparam int CNT_W = $clog2(MAX_KNOTS + 1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic mode_ff;
   logic [CSR_W-1:0] count_ff;
   logic [CNT_W-1:0] n_w;
   logic [IDX_W-1:0] last_idx;
   logic n_zero, n_one, is_last, query_take;

   // knots in use, limited to the table depth
   always_comb begin
      if (int'(count_ff) > MAX_KNOTS) begin
         n_w = CNT_W'(MAX_KNOTS);
      end else begin
         n_w = CNT_W'(count_ff);
      end
   end

   assign last_idx = IDX_W'(n_w - CNT_W'(1));
   assign n_zero = (n_w == '0);
   assign n_one = (n_w == CNT_W'(1));
   assign is_last = (idx_ff == last_idx);
   assign query_take = req_tvalid && (req_tuser == CMD_QUERY);
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
         count_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IDX_MODE: mode_ff <= csr_data[0];
            CSR_IDX_COUNT: count_ff <= csr_data;
            default: mode_ff <= mode_ff;
         endcase
      end
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         ch_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         ch_ff <= ch_in;
         step_ff <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_take) begin
               state_in = n_zero ? ST_DELIVER : ST_CHK_FIRST;
            end
         end
         ST_CHK_FIRST: begin
            if (n_one || status.t_le_rd) begin
               state_in = ST_DELIVER;
            end else if (mode_ff == MODE_NEAREST) begin
               state_in = ST_CHK_SCAN;
            end else begin
               state_in = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            state_in = status.t_ge_rd ? ST_DELIVER : ST_CHK_SCAN;
         end
         ST_CHK_SCAN: begin
            if (status.seg_found) begin
               state_in = (mode_ff == MODE_NEAREST) ? ST_NEAR : ST_SPAN;
            end else if (is_last) begin
               state_in = ST_DELIVER;
            end
         end
         ST_NEAR: state_in = ST_DELIVER;
         ST_SPAN: state_in = status.span_zero ? ST_DELIVER : ST_PREP;
         ST_PREP: state_in = ST_MUL;
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: state_in = (ch_ff == CH_LAST) ? ST_DELIVER : ST_PREP;
         ST_DELIVER: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands and counter updates
   always_comb begin
      cmd = '0;
      cmd.res_sel = RES_HOLD;
      cmd.ch = ch_ff;
      rd_addr = '0;
      req_tready = 1'b0;
      idx_in = idx_ff;
      ch_in = ch_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take = req_tvalid;
            if (query_take && n_zero) begin
               cmd.res_sel = RES_ZERO;
            end
         end
         ST_CHK_FIRST: begin
            cmd.load_prev = 1'b1;
            if (n_one || status.t_le_rd) begin
               cmd.res_sel = RES_RD;
            end else if (mode_ff == MODE_NEAREST) begin
               rd_addr = IDX_W'(1);
               idx_in = IDX_W'(1);
            end else begin
               rd_addr = last_idx;
            end
         end
         ST_CHK_LAST: begin
            if (status.t_ge_rd) begin
               cmd.res_sel = RES_RD;
            end else begin
               rd_addr = IDX_W'(1);
               idx_in = IDX_W'(1);
            end
         end
         ST_CHK_SCAN: begin
            cmd.load_cur = 1'b1;
            if (!status.seg_found) begin
               if (is_last) begin
                  cmd.res_sel = RES_RD;
               end else begin
                  cmd.load_prev = 1'b1;
                  idx_in = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_NEAR: cmd.res_sel = status.cur_closer ? RES_CUR : RES_PREV;
         ST_SPAN: begin
            if (status.span_zero) begin
               cmd.res_sel = RES_PREV;
            end
            ch_in = '0;
         end
         ST_PREP: cmd.prep = 1'b1;
         ST_MUL: begin
            cmd.mul = 1'b1;
            step_in = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + STEP_W'(1);
         end
         ST_FIN: begin
            cmd.res_sel = RES_LIN;
            if (ch_ff != CH_LAST) begin
               ch_in = ch_ff + CH_W'(1);
            end
         end
         ST_DELIVER: cmd.rsp_load = status.rsp_free;
         default: cmd.take = 1'b0;
      endcase
   end

`ifndef SYNTHESIS
   // a query never returns to idle in the cycle after it is taken
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && query_take) |=> (state_ff != ST_IDLE))
      else $error("query taken but controller idle");
   // channel counter stays within the three channels
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      (ch_ff <= CH_LAST))
      else $error("channel counter out of range");
   // the divider always runs the full step count
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == STEP_LAST) |=> (state_ff == ST_FIN))
      else $error("division ended early or late");
`endif

endmodule

>>> rtl/core/kfi_dp.sv
// datapath: knot memory, segment compares, multiplier, serial divider, result register
module kfi_dp #(
   parameter int MAX_KNOTS = 16,
   parameter int IDX_W = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic [kfi_pkg::REQ_W-1:0] req_tdata,
   input  logic req_tuser,
   input  kfi_pkg::cmd_type cmd,
   input  logic [IDX_W-1:0] rd_addr,
   output kfi_pkg::status_type status,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [kfi_pkg::RSP_W-1:0] rsp_tdata
);
   import kfi_pkg::*;

   knot_type mem [MAX_KNOTS];
   knot_type rd_ff, prev_ff, cur_ff, wr_knot;
   logic [VAL_W-1:0] qt_ff;
   logic [CH_N-1:0][VAL_W-1:0] res_ff, rsp_data_ff;
   logic rsp_tvalid_ff;
   logic [VAL_W-1:0] mag_a_ff, mag_b_ff, div_ff, y0_ff, rem_ff;
   logic neg_ff;
   logic [2*VAL_W-1:0] dvd_ff;
   logic [VAL_W:0] dt_w, dy_w, span_w, dq_w, dp_w, mdq_w, mdp_w, rem_sh, rem_sub;
   logic [VAL_W-1:0] lin_w;
   logic wr_en;

   assign wr_knot = knot_type'(req_tdata[131:4]);
   assign wr_en = cmd.take && (req_tuser == CMD_LOAD) && (int'(req_tdata[3:0]) < MAX_KNOTS);

   // knot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[IDX_W'(req_tdata[3:0])] <= wr_knot;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   // query time and segment end points
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         qt_ff <= req_tdata[163:132];
      end
      if (cmd.load_prev) begin
         prev_ff <= rd_ff;
      end
      if (cmd.load_cur) begin
         cur_ff <= rd_ff;
      end
   end

   // compares against the knot under test
   assign status.t_le_rd = ($signed(qt_ff) <= $signed(rd_ff.tm));
   assign status.t_ge_rd = ($signed(qt_ff) >= $signed(rd_ff.tm));
   assign status.seg_found = ($signed(qt_ff) >= $signed(prev_ff.tm)) && status.t_le_rd;
   assign status.span_zero = (cur_ff.tm == prev_ff.tm);

   // nearest pick, tie goes to the earlier knot
   assign dq_w = {qt_ff[VAL_W-1], qt_ff} - {cur_ff.tm[VAL_W-1], cur_ff.tm};
   assign dp_w = {qt_ff[VAL_W-1], qt_ff} - {prev_ff.tm[VAL_W-1], prev_ff.tm};
   assign mdq_w = dq_w[VAL_W] ? -dq_w : dq_w;
   assign mdp_w = dp_w[VAL_W] ? -dp_w : dp_w;
   assign status.cur_closer = (mdq_w < mdp_w);

   // operand preparation for one channel
   assign dt_w = dp_w;
   assign dy_w = {cur_ff.val[cmd.ch][VAL_W-1], cur_ff.val[cmd.ch]}
      - {prev_ff.val[cmd.ch][VAL_W-1], prev_ff.val[cmd.ch]};
   assign span_w = {cur_ff.tm[VAL_W-1], cur_ff.tm} - {prev_ff.tm[VAL_W-1], prev_ff.tm};

   // restoring division step
   assign rem_sh = {rem_ff, dvd_ff[2*VAL_W-1]};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         mag_a_ff <= dt_w[VAL_W] ? VAL_W'(-dt_w) : dt_w[VAL_W-1:0];
         mag_b_ff <= dy_w[VAL_W] ? VAL_W'(-dy_w) : dy_w[VAL_W-1:0];
         div_ff <= span_w[VAL_W] ? VAL_W'(-span_w) : span_w[VAL_W-1:0];
         neg_ff <= dt_w[VAL_W] ^ dy_w[VAL_W] ^ span_w[VAL_W];
         y0_ff <= prev_ff.val[cmd.ch];
      end
      if (cmd.mul) begin
         dvd_ff <= {{VAL_W{1'b0}}, mag_a_ff} * {{VAL_W{1'b0}}, mag_b_ff};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!rem_sub[VAL_W]) begin
            rem_ff <= rem_sub[VAL_W-1:0];
            dvd_ff <= {dvd_ff[2*VAL_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[VAL_W-1:0];
            dvd_ff <= {dvd_ff[2*VAL_W-2:0], 1'b0};
         end
      end
   end

   // signed result of one channel
   assign lin_w = neg_ff ? (y0_ff - dvd_ff[VAL_W-1:0]) : (y0_ff + dvd_ff[VAL_W-1:0]);

   // result staging
   always_ff @(posedge clock) begin
      unique case (cmd.res_sel)
         RES_HOLD: res_ff <= res_ff;
         RES_ZERO: res_ff <= '0;
         RES_RD: res_ff <= rd_ff.val;
         RES_PREV: res_ff <= prev_ff.val;
         RES_CUR: res_ff <= cur_ff.val;
         RES_LIN: res_ff[cmd.ch] <= lin_w;
         default: res_ff <= res_ff;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign status.rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   // a result is only loaded when the output slot is free
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result overwritten before transfer");
   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < div_ff))
      else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/core/keyframe_interpolator.sv
// keyframe interpolator top level: controller plus datapath
// Usage:
//   req channel: tuser is the command (0 load, 1 query). A load transfer
//   writes one knot (time and channels a, b, c) into the slot knot_index
//   and gives no result; a query transfer gives one rsp transfer with the
//   three channels at query_time, nearest or linear, from the first
//   knot_count slots. All values are signed Q16.16.
//   csr channel: index 0 interp_mode, index 1 knot_count; always ready;
//   write only while the block is idle.
// Sequence of a query (from the query transfer to rsp_tvalid):
//   a query with an empty table goes straight to the result; otherwise
//   the first knot, then in linear mode the last knot, may answer it, else
//   a segment scan reads one knot per cycle, set by the single read port
//   of the knot memory. Nearest mode picks the closer end of the segment;
//   linear mode works each of the three channels with one prepare, one
//   32x32 multiply, a 64-step serial divide and one result step. One item is worked on at a time.
// Reset clears the state machine, the registers (linear mode, no knots)
// and the output valid; knot memory keeps its contents. A stalled rsp
// side holds the finished result in the output register while further
// loads are still taken; the next query is taken and worked on, then its
// result waits and req_tready stays low until that slot frees.
module keyframe_interpolator #(
   parameter int MAX_KNOTS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: knot_index[3:0], knot_time[35:4], knot_value_a[67:36],
   // knot_value_b[99:68], knot_value_c[131:100], query_time[163:132], zero pad
   input  logic [kfi_pkg::REQ_W-1:0] req_tdata,
   // tuser: command[0]
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: result_a[31:0], result_b[63:32], result_c[95:64]
   output logic [kfi_pkg::RSP_W-1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [kfi_pkg::CSR_W-1:0] csr_data
);
   import kfi_pkg::*;

   localparam int IDX_W = $clog2(MAX_KNOTS);

   cmd_type cmd;
   status_type status;
   logic [IDX_W-1:0] rd_addr;

   // sequencing
   kfi_ctrl #(
      .MAX_KNOTS(MAX_KNOTS),
      .IDX_W(IDX_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .status(status),
      .cmd(cmd),
      .rd_addr(rd_addr)
   );

   // storage and arithmetic
   kfi_dp #(
      .MAX_KNOTS(MAX_KNOTS),
      .IDX_W(IDX_W)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .status(status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule
